### hdl/pair_ratio_interleave_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pair ratio interleave sequencer
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef PAIR_RATIO_INTERLEAVE_SEQUENCER_UNIT_DEFINES_SVH
`define PAIR_RATIO_INTERLEAVE_SEQUENCER_UNIT_DEFINES_SVH

// Property checked on every clock edge, masked while reset is held.
`define PRISU_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define PRISU_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/prisu_pkg.sv
// ----------------------------------------------------------------------------
// prisu_pkg
// Types and constants shared by the pair ratio interleave sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prisu_pkg;

    localparam int unsigned ID_W       = 8;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned SHARE_W    = 7;
    localparam int unsigned CFG_DATA_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRST_COMPONENT  = 2'd0,
        REG_SECOND_COMPONENT = 2'd1,
        REG_SHARE_B_PERCENT  = 2'd2,
        REG_LIMIT_CYCLE_ON   = 2'd3
    } cfg_reg_t;

    localparam logic [SHARE_W-1:0] FULL_PERCENT = 7'd100;
    localparam logic [SHARE_W-1:0] HALF_PERCENT = 7'd50;
    localparam logic [POS_W-1:0]   MAX_CYCLE    = 7'd24;

    typedef struct packed {
        logic [POS_W-1:0] ratio_a;
        logic [POS_W-1:0] ratio_b;
        logic [POS_W-1:0] cycle_len;
    } ratio_t;

    typedef struct packed {
        logic             emit;
        logic             pick_b;
        logic [POS_W-1:0] position;
        logic             cycle_last;
        logic [POS_W-1:0] pos_next;
        logic [POS_W-1:0] acc_next;
    } step_t;

    localparam logic [ID_W-1:0]    RST_FIRST_COMPONENT  = 8'd1;
    localparam logic [ID_W-1:0]    RST_SECOND_COMPONENT = 8'd2;
    localparam logic [SHARE_W-1:0] RST_SHARE_B_PERCENT  = 7'd50;
    localparam logic               RST_LIMIT_CYCLE_ON   = 1'b1;
    // 50 percent gives 1:1 over a cycle of two layers
    localparam ratio_t RST_RATIO = '{ratio_a: 7'd1, ratio_b: 7'd1, cycle_len: 7'd2};

endpackage

### hdl/prisu_ratio.sv
// ----------------------------------------------------------------------------
// prisu_ratio
// Maps the B share and the limit flag to the A:B layer ratio.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prisu_ratio (
    input  logic [prisu_pkg::SHARE_W-1:0] share_b_percent,
    input  logic                          limit_cycle_on,
    output prisu_pkg::ratio_t             ratio
);

    logic [prisu_pkg::SHARE_W-1:0] mix;
    logic [prisu_pkg::SHARE_W-1:0] minor;
    logic [prisu_pkg::POS_W-1:0]   layers;
    logic [prisu_pkg::POS_W-1:0]   major_s;
    logic [prisu_pkg::POS_W-1:0]   minor_s;
    logic                          b_major;

    // Except at 0 and 100 percent, the minor side gets one layer, so the gcd step never reduces.
    always_comb begin
        mix     = (share_b_percent > prisu_pkg::FULL_PERCENT) ?
                  prisu_pkg::FULL_PERCENT : share_b_percent;
        b_major = (mix >= prisu_pkg::HALF_PERCENT);
        minor   = b_major ? (prisu_pkg::FULL_PERCENT - mix) : mix;

        // round((100 - minor) / minor), half away from zero
        case (minor) inside
            7'd1:      layers = 7'd99;
            7'd2:      layers = 7'd49;
            7'd3:      layers = 7'd32;
            7'd4:      layers = 7'd24;
            7'd5:      layers = 7'd19;
            7'd6:      layers = 7'd16;
            7'd7:      layers = 7'd13;
            7'd8:      layers = 7'd12;
            7'd9:      layers = 7'd10;
            7'd10:     layers = 7'd9;
            7'd11:     layers = 7'd8;
            [7'd12:7'd13]: layers = 7'd7;
            [7'd14:7'd15]: layers = 7'd6;
            [7'd16:7'd18]: layers = 7'd5;
            [7'd19:7'd22]: layers = 7'd4;
            [7'd23:7'd28]: layers = 7'd3;
            [7'd29:7'd40]: layers = 7'd2;
            [7'd41:7'd50]: layers = 7'd1;
            default:   layers = 7'd1;
        endcase

        // With limit_cycle_on set, scale cycles longer than 24 to 24 or 25
        // layers; the minor side floors at 1.
        minor_s = 7'd1;
        if (limit_cycle_on && (layers >= prisu_pkg::MAX_CYCLE)) begin
            major_s = (layers >= 7'd49) ? prisu_pkg::MAX_CYCLE : (prisu_pkg::MAX_CYCLE - 7'd1);
        end else begin
            major_s = layers;
        end

        if (mix == '0) begin
            ratio.ratio_a = 7'd1;
            ratio.ratio_b = 7'd0;
        end else if (mix == prisu_pkg::FULL_PERCENT) begin
            ratio.ratio_a = 7'd0;
            ratio.ratio_b = 7'd1;
        end else begin
            ratio.ratio_a = b_major ? minor_s : major_s;
            ratio.ratio_b = b_major ? major_s : minor_s;
        end
        ratio.cycle_len = ratio.ratio_a + ratio.ratio_b;
    end

endmodule

### hdl/prisu_spread.sv
// ----------------------------------------------------------------------------
// prisu_spread
// One Bresenham step: picks the layer's component and the next position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prisu_spread (
    input  logic                          restart,
    input  logic [prisu_pkg::POS_W-1:0]   pos_reg,
    input  logic [prisu_pkg::POS_W-1:0]   acc_reg,
    input  prisu_pkg::ratio_t             ratio,
    input  logic [prisu_pkg::ID_W-1:0]    first_component,
    input  logic [prisu_pkg::ID_W-1:0]    second_component,
    output prisu_pkg::step_t              step
);

    logic [prisu_pkg::POS_W-1:0] pos;
    logic [prisu_pkg::POS_W-1:0] acc;
    logic [prisu_pkg::POS_W-1:0] pos_w;
    logic [prisu_pkg::POS_W-1:0] acc_w;
    logic [prisu_pkg::POS_W:0]   acc_sum;
    logic [prisu_pkg::POS_W:0]   pos_inc;
    logic [prisu_pkg::POS_W:0]   len_x;
    logic [prisu_pkg::POS_W:0]   acc_wrap;
    logic                        ids_ok;

    always_comb begin
        pos    = restart ? '0 : pos_reg;
        acc    = restart ? '0 : acc_reg;
        ids_ok = (first_component != '0) && (second_component != '0) &&
                 (first_component != second_component);

        // Recover from a position left over from a longer cycle.
        if ((pos >= ratio.cycle_len) || (acc >= ratio.cycle_len)) begin
            pos_w = '0;
            acc_w = '0;
        end else begin
            pos_w = pos;
            acc_w = acc;
        end

        len_x    = {1'b0, ratio.cycle_len};
        acc_sum  = {1'b0, acc_w} + {1'b0, ratio.ratio_b};
        pos_inc  = {1'b0, pos_w} + 8'd1;
        acc_wrap = (acc_sum >= len_x) ? (acc_sum - len_x) : acc_sum;

        step.emit       = ids_ok;
        step.pick_b     = (acc_sum >= len_x);
        step.position   = pos_w;
        step.cycle_last = (pos_inc == len_x);

        if (!ids_ok) begin
            // hold position, keeping only the restart
            step.pos_next = pos;
            step.acc_next = acc;
        end else if (pos_inc >= len_x) begin
            step.pos_next = '0;
            step.acc_next = '0;
        end else begin
            step.pos_next = pos_inc[prisu_pkg::POS_W-1:0];
            step.acc_next = acc_wrap[prisu_pkg::POS_W-1:0];
        end
    end

endmodule

### hdl/pair_ratio_interleave_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pair_ratio_interleave_sequencer_unit
// Two-component layer interleaver with a Bresenham spread of component B.
// ----------------------------------------------------------------------------
// The block takes one transfer per clock on the s_ channel and returns at most
// one result transfer per input on the m_ channel; each result passes through
// the input register and then the result register. Each input with valid ids
// advances the cycle position by one layer; s_restart first returns the
// cycle to position zero. The A:B ratio is looked up from share_b_percent and
// limit_cycle_on as each configuration write lands, so the per-layer work is
// one add and compare against the cycle length. While a result waits in the
// output register, the input register takes one more transfer and then holds
// s_ready low until m_ready returns; throughput is one item per cycle as long
// as m_ready is high. When an id is zero or the two ids are equal, inputs are consumed
// without a result (restart still takes effect).
// Configuration writes re-derive the ratio and clear the cycle position; write
// them only while no transfer is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pair_ratio_interleave_sequencer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_restart,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [prisu_pkg::ID_W-1:0]       m_component_id,
    output logic [prisu_pkg::POS_W-1:0]      m_position,
    output logic                             m_cycle_last,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [prisu_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prisu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // configuration
    logic [prisu_pkg::ID_W-1:0]    first_reg,  first_next;
    logic [prisu_pkg::ID_W-1:0]    second_reg, second_next;
    logic [prisu_pkg::SHARE_W-1:0] share_reg,  share_next;
    logic                          limit_reg,  limit_next;
    prisu_pkg::ratio_t             ratio_reg,  ratio_next;

    // cycle state
    logic [prisu_pkg::POS_W-1:0]   pos_reg;
    logic [prisu_pkg::POS_W-1:0]   acc_reg;

    // input register
    logic                          in_vld_reg;
    logic                          restart_reg;

    // result register
    logic                          m_vld_reg;
    logic [prisu_pkg::ID_W-1:0]    id_reg;
    logic [prisu_pkg::POS_W-1:0]   position_reg;
    logic                          last_reg;

    prisu_pkg::step_t              step;
    logic                          advance;

    // Decode the write so the ratio is derived from the value being written.
    always_comb begin
        first_next  = first_reg;
        second_next = second_reg;
        share_next  = share_reg;
        limit_next  = limit_reg;
        if (cfg_we) begin
            case (prisu_pkg::cfg_reg_t'(cfg_index))
                prisu_pkg::REG_FIRST_COMPONENT:  first_next  = cfg_wdata;
                prisu_pkg::REG_SECOND_COMPONENT: second_next = cfg_wdata;
                prisu_pkg::REG_SHARE_B_PERCENT:  share_next  = cfg_wdata[prisu_pkg::SHARE_W-1:0];
                prisu_pkg::REG_LIMIT_CYCLE_ON:   limit_next  = cfg_wdata[0];
                default: begin
                    first_next = first_reg;
                end
            endcase
        end
    end

    prisu_ratio u_ratio (
        .share_b_percent (share_next),
        .limit_cycle_on  (limit_next),
        .ratio           (ratio_next)
    );

    prisu_spread u_spread (
        .restart          (restart_reg),
        .pos_reg          (pos_reg),
        .acc_reg          (acc_reg),
        .ratio            (ratio_reg),
        .first_component  (first_reg),
        .second_component (second_reg),
        .step             (step)
    );

    // Process the held item when the result register is free or draining.
    assign advance = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= prisu_pkg::RST_FIRST_COMPONENT;
            second_reg <= prisu_pkg::RST_SECOND_COMPONENT;
            share_reg  <= prisu_pkg::RST_SHARE_B_PERCENT;
            limit_reg  <= prisu_pkg::RST_LIMIT_CYCLE_ON;
            ratio_reg  <= prisu_pkg::RST_RATIO;
        end else if (cfg_we) begin
            first_reg  <= first_next;
            second_reg <= second_next;
            share_reg  <= share_next;
            limit_reg  <= limit_next;
            ratio_reg  <= ratio_next;
        end
    end

    // Cycle state: a configuration write restarts the cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            acc_reg <= '0;
        end else if (cfg_we) begin
            pos_reg <= '0;
            acc_reg <= '0;
        end else if (advance) begin
            pos_reg <= step.pos_next;
            acc_reg <= step.acc_next;
        end
    end

    // Input register: take a new transfer as the held one moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            restart_reg <= s_restart;
        end
    end

    // Result register: load on an emitting step, drop once transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (advance && step.emit) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && step.emit) begin
            id_reg       <= step.pick_b ? second_reg : first_reg;
            position_reg <= step.position;
            last_reg     <= step.cycle_last;
        end
    end

    assign m_valid        = m_vld_reg;
    assign m_component_id = id_reg;
    assign m_position     = position_reg;
    assign m_cycle_last   = last_reg;

endmodule

### hdl/prisu_checker.sv
// ----------------------------------------------------------------------------
// prisu_checker
// Port-level checks for the pair ratio interleave sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pair_ratio_interleave_sequencer_unit_defines.svh"

module prisu_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [prisu_pkg::ID_W-1:0]       m_component_id,
    input logic [prisu_pkg::POS_W-1:0]      m_position,
    input logic                             m_cycle_last
);

    // A stalled result holds its payload.
    `PRISU_ASSERT_RST(a_result_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_component_id) && $stable(m_position) && $stable(m_cycle_last)), "result changed while stalled")

    // Zero ids never reach the output.
    `PRISU_ASSERT_RST(a_id_nonzero, aclk, aresetn, m_valid |-> (m_component_id != '0), "zero component id emitted")

    // Cycle is at most 100 layers long.
    `PRISU_ASSERT_RST(a_position_range, aclk, aresetn, m_valid |-> (m_position < prisu_pkg::FULL_PERCENT), "position beyond cycle")

    // Reset empties the result register.
    `PRISU_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind pair_ratio_interleave_sequencer_unit prisu_checker u_prisu_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_component_id (m_component_id),
    .m_position     (m_position),
    .m_cycle_last   (m_cycle_last)
);
